// File: hw/rtl/oaht_pkg.sv
// Shared constants for the open addressing hash table.
// Used by open_addressing_hash_table_unit and the testbench; no other dependencies.
package oaht_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    localparam logic [31:0] HASH_START = 32'd5381;
    localparam int          HASH_SHIFT = 5;

    // request operation codes
    localparam logic [2:0] MODE_SET   = 3'd0;
    localparam logic [2:0] MODE_GET   = 3'd1;
    localparam logic [2:0] MODE_ERASE = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_ITER  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ITER_END = 2'd3;

    // per-slot flag word: bit 0 in use, bit 1 tombstone
    localparam logic [1:0] FLAG_EMPTY = 2'b00;
    localparam logic [1:0] FLAG_LIVE  = 2'b01;
    localparam logic [1:0] FLAG_TOMB  = 2'b11;

endpackage

// File: hw/rtl/open_addressing_hash_table_unit.sv
// Open addressing hash table: djb2 hash, linear probing, tombstones.
// Depends on oaht_pkg.
//
//  channel | direction | handshake              | payload
//  request | in        | i_in_valid / o_in_stall | i_mode i_key i_value i_after_slot
//  result  | out       | o_out_valid / i_out_stall | o_status o_value_out o_key_out
//          |           |                         | o_slot_out o_live_count
//  config  | in        | i_cfg_we               | i_cfg_data (capacity in use)
//
// Set, get, erase: an accept step, hash steps over the four key bytes, a remainder
// over the 32 hash bits (one bit per cycle), a slot memory read then check per probe,
// and a result step. Iterate: accept, a read and check per slot scanned, result.
// Clear: accept, a flag sweep over all 1024 slots, result. Other modes: accept, result.
// After reset a clearing pass over all 1024 slots runs; o_in_stall stays high meanwhile.
// One request is worked at a time; a waiting result holds only the final step.
module open_addressing_hash_table_unit
    import oaht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_mode,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic signed [10:0] i_after_slot,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [VAL_W-1:0]  o_value_out,
    output logic [KEY_W-1:0]  o_key_out,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [CNT_W-1:0]  o_live_count,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_HASH = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_CHK  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [2:0]        r_mode, n_mode;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [31:0]       r_hash, n_hash;
    logic [SLOT_W-1:0] r_rem, n_rem;
    logic [4:0]        r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_probes, n_probes;
    logic [SLOT_W-1:0] r_free, n_free;
    logic              r_free_ok, n_free_ok;
    logic              r_clr_op, n_clr_op;

    // pending result
    logic [1:0]        r_res_status, n_res_status;
    logic [VAL_W-1:0]  r_res_val, n_res_val;
    logic [KEY_W-1:0]  r_res_key, n_res_key;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;

    // slot memories
    logic [1:0]        r_mem_flag [SLOTS];
    logic [KEY_W-1:0]  r_mem_key  [SLOTS];
    logic [VAL_W-1:0]  r_mem_val  [SLOTS];
    logic [1:0]        r_rd_flag;
    logic [KEY_W-1:0]  r_rd_key;
    logic [VAL_W-1:0]  r_rd_val;

    logic              we_flag, we_key, we_val;
    logic [SLOT_W-1:0] wr_addr;
    logic [1:0]        wr_flag;

    // shared arithmetic
    logic [31:0]       hash_step;
    logic [CNT_W-1:0]  rem_shift;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  slot_inc;
    logic [CNT_W-1:0]  iter_start;
    logic              out_free;

    assign cap_eff = (r_cap == '0) ? CNT_W'(1) :
                     (r_cap > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : r_cap;

    assign hash_step = (r_hash << HASH_SHIFT) + r_hash + {24'd0, r_key[8*r_cnt[1:0] +: 8]};
    assign rem_shift = {r_rem, r_hash[31]};
    assign rem_next  = (rem_shift >= cap_eff) ? rem_shift - cap_eff : rem_shift;
    assign slot_inc  = {1'b0, r_slot} + CNT_W'(1);
    assign iter_start = i_after_slot[10] ? '0 : CNT_W'(i_after_slot) + CNT_W'(1);
    assign out_free  = !o_out_valid || !i_out_stall;

    assign o_in_stall = (r_state != S_IDLE);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_mode       = r_mode;
        n_key        = r_key;
        n_val        = r_val;
        n_hash       = r_hash;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_slot       = r_slot;
        n_probes     = r_probes;
        n_free       = r_free;
        n_free_ok    = r_free_ok;
        n_clr_op     = r_clr_op;
        n_res_status = r_res_status;
        n_res_val    = r_res_val;
        n_res_key    = r_res_key;
        n_res_slot   = r_res_slot;
        we_flag      = 1'b0;
        we_key       = 1'b0;
        we_val       = 1'b0;
        wr_addr      = r_slot;
        wr_flag      = FLAG_EMPTY;
        unique case (r_state)
            S_CLR: begin
                we_flag = 1'b1;
                n_slot  = r_slot + SLOT_W'(1);
                if (r_slot == SLOT_W'(SLOTS - 1)) begin
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode       = i_mode;
                    n_key        = i_key;
                    n_val        = i_value;
                    n_hash       = HASH_START;
                    n_cnt        = '0;
                    n_res_status = ST_OK;
                    n_res_val    = '0;
                    n_res_key    = '0;
                    n_res_slot   = '0;
                    unique case (i_mode) inside
                        MODE_SET, MODE_GET, MODE_ERASE: n_state = S_HASH;
                        MODE_CLEAR: begin
                            n_count  = '0;
                            n_slot   = '0;
                            n_clr_op = 1'b1;
                            n_state  = S_CLR;
                        end
                        MODE_ITER: begin
                            if (iter_start >= cap_eff) begin
                                n_res_status = ST_ITER_END;
                                n_state      = S_DONE;
                            end else begin
                                n_slot  = iter_start[SLOT_W-1:0];
                                n_state = S_RD;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_HASH: begin
                n_hash = hash_step;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd3) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // restoring remainder, one hash bit per cycle
                n_rem  = rem_next[SLOT_W-1:0];
                n_hash = {r_hash[30:0], 1'b0};
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_slot    = rem_next[SLOT_W-1:0];
                    n_probes  = '0;
                    n_free_ok = 1'b0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_mode == MODE_ITER) begin
                    if (r_rd_flag == FLAG_LIVE) begin
                        n_res_val  = r_rd_val;
                        n_res_key  = r_rd_key;
                        n_res_slot = r_slot;
                        n_state    = S_DONE;
                    end else if (slot_inc >= cap_eff) begin
                        n_res_status = ST_ITER_END;
                        n_state      = S_DONE;
                    end else begin
                        n_slot  = slot_inc[SLOT_W-1:0];
                        n_state = S_RD;
                    end
                end else begin
                    n_probes = r_probes + CNT_W'(1);
                    n_slot   = (slot_inc == cap_eff) ? '0 : slot_inc[SLOT_W-1:0];
                    n_state  = S_RD;
                    if (!r_rd_flag[0]) begin
                        // never-used slot ends the probe
                        n_state = S_DONE;
                        if (r_mode == MODE_SET) begin
                            wr_addr    = r_free_ok ? r_free : r_slot;
                            wr_flag    = FLAG_LIVE;
                            we_flag    = 1'b1;
                            we_key     = 1'b1;
                            we_val     = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                            n_res_slot = wr_addr;
                        end else begin
                            n_res_status = ST_MISS;
                        end
                    end else if (r_rd_flag[1]) begin
                        if (!r_free_ok) begin
                            n_free    = r_slot;
                            n_free_ok = 1'b1;
                        end
                    end else if (r_rd_key == r_key) begin
                        n_state    = S_DONE;
                        n_res_slot = r_slot;
                        unique case (r_mode)
                            MODE_SET: we_val = 1'b1;
                            MODE_GET: n_res_val = r_rd_val;
                            default: begin
                                wr_flag = FLAG_TOMB;
                                we_flag = 1'b1;
                                if (r_count != '0) n_count = r_count - CNT_W'(1);
                            end
                        endcase
                    end
                    // probe budget spent without a decision
                    if (n_state == S_RD && n_probes == cap_eff) begin
                        n_state = S_DONE;
                        if (r_mode == MODE_SET && (r_free_ok || n_free_ok)) begin
                            wr_addr    = n_free;
                            wr_flag    = FLAG_LIVE;
                            we_flag    = 1'b1;
                            we_key     = 1'b1;
                            we_val     = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                            n_res_slot = n_free;
                        end else if (r_mode == MODE_SET) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_res_status = ST_MISS;
                        end
                    end
                end
            end
            S_DONE: begin
                n_clr_op = 1'b0;
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cap    <= CNT_W'(SLOTS);
            r_count  <= '0;
            r_slot   <= '0;
            r_clr_op <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_slot   <= n_slot;
            r_clr_op <= n_clr_op;
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (r_state == S_DONE && out_free) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_val        <= n_val;
        r_hash       <= n_hash;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_probes     <= n_probes;
        r_free       <= n_free;
        r_free_ok    <= n_free_ok;
        r_res_status <= n_res_status;
        r_res_val    <= n_res_val;
        r_res_key    <= n_res_key;
        r_res_slot   <= n_res_slot;
        if (r_state == S_DONE && out_free) begin
            o_status     <= r_res_status;
            o_value_out  <= r_res_val;
            o_key_out    <= r_res_key;
            o_slot_out   <= r_res_slot;
            o_live_count <= r_count;
        end
    end

    // slot memories, registered read at the probe address
    always_ff @(posedge i_clk) begin
        if (we_flag) r_mem_flag[wr_addr] <= wr_flag;
        if (we_key)  r_mem_key[wr_addr]  <= r_key;
        if (we_val)  r_mem_val[wr_addr]  <= r_val;
        r_rd_flag <= r_mem_flag[r_slot];
        r_rd_key  <= r_mem_key[r_slot];
        r_rd_val  <= r_mem_val[r_slot];
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("live count above slot total");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken without going busy");

    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> ($past(r_state) == S_RD))
        else $error("slot check without a memory read");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside result step");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for open_addressing_hash_table_unit.
// Depends on oaht_pkg and the unit; a clocked driver and monitor are checked
// against a table model that is kept inside this file.
`timescale 1ns / 1ps

module tb
    import oaht_pkg::*;
();

    localparam int HOLD_LIMIT = 20000;   // cycles without any handshake
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic [2:0]        mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic signed [10:0] after_slot;
    } t_table_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [VAL_W-1:0]  value_out;
        logic [KEY_W-1:0]  key_out;
        logic [SLOT_W-1:0] slot_out;
        logic [CNT_W-1:0]  live_count;
    } t_table_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_mode;
    logic [KEY_W-1:0]  i_key;
    logic [VAL_W-1:0]  i_value;
    logic signed [10:0] i_after_slot;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_status;
    logic [VAL_W-1:0]  o_value_out;
    logic [KEY_W-1:0]  o_key_out;
    logic [SLOT_W-1:0] o_slot_out;
    logic [CNT_W-1:0]  o_live_count;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_data;

    // model of the table contents
    logic              live_flag [SLOTS];
    logic              tomb_flag [SLOTS];
    logic [KEY_W-1:0]  key_store [SLOTS];
    logic [VAL_W-1:0]  val_store [SLOTS];
    int unsigned       entries;
    int unsigned       cap_reg;

    t_table_req        pending_reqs[$];
    t_table_result     expected_results[$];
    t_table_req        cur_req;
    logic [KEY_W-1:0]  key_pool [16];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int hold_request;
    int mismatches;
    int quiet_cycles;

    open_addressing_hash_table_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_after_slot (i_after_slot),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_value_out  (o_value_out),
        .o_key_out    (o_key_out),
        .o_slot_out   (o_slot_out),
        .o_live_count (o_live_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // djb2 over the four key bytes, lowest byte first
    function automatic logic [31:0] djb2_hash(logic [KEY_W-1:0] k);
        logic [31:0] h;
        h = HASH_START;
        for (int i = 0; i < 4; i++)
            h = (h << HASH_SHIFT) + h + {24'd0, k[8*i +: 8]};
        return h;
    endfunction

    // work one request on the model, returning the result it must give
    function automatic t_table_result apply_request(t_table_req r);
        t_table_result res;
        int unsigned   c;
        int unsigned   home;
        int unsigned   s;
        int            free_slot;
        int            hit;
        int            after;
        res = '0;
        c = cap_reg;
        if (c < 1) c = 1;
        if (c > SLOTS) c = SLOTS;
        home = djb2_hash(r.key) % c;
        free_slot = -1;
        hit = -1;
        if (r.mode inside {MODE_SET, MODE_GET, MODE_ERASE}) begin
            for (int i = 0; i < c; i++) begin
                s = (home + i) % c;
                if (!live_flag[s]) begin
                    if (free_slot < 0) free_slot = s;
                    break;
                end
                if (tomb_flag[s]) begin
                    if (free_slot < 0) free_slot = s;
                    continue;
                end
                if (key_store[s] == r.key) begin
                    hit = s;
                    break;
                end
            end
        end
        case (r.mode)
            MODE_SET: begin
                if (hit >= 0) begin
                    val_store[hit] = r.value;
                    res.slot_out = SLOT_W'(hit);
                end else if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    live_flag[free_slot] = 1'b1;
                    tomb_flag[free_slot] = 1'b0;
                    key_store[free_slot] = r.key;
                    val_store[free_slot] = r.value;
                    entries++;
                    res.slot_out = SLOT_W'(free_slot);
                end
            end
            MODE_GET: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.value_out = val_store[hit];
                    res.slot_out = SLOT_W'(hit);
                end
            end
            MODE_ERASE: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    tomb_flag[hit] = 1'b1;
                    if (entries > 0) entries--;
                    res.slot_out = SLOT_W'(hit);
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    live_flag[i] = 1'b0;
                    tomb_flag[i] = 1'b0;
                end
                entries = 0;
            end
            MODE_ITER: begin
                after = r.after_slot;
                if (after < -1) after = -1;
                res.status = ST_ITER_END;
                for (int i = after + 1; i < c; i++) begin
                    if (live_flag[i] && !tomb_flag[i]) begin
                        res.status = ST_OK;
                        res.value_out = val_store[i];
                        res.key_out = key_store[i];
                        res.slot_out = SLOT_W'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.live_count = CNT_W'(entries);
        return res;
    endfunction

    // request driver: holds a stalled request, otherwise takes the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(apply_request(cur_req));
            if (i_in_valid && o_in_stall) begin
                // payload held
            end else if (pending_reqs.size() > 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                i_in_valid   <= 1'b1;
                i_mode       <= cur_req.mode;
                i_key        <= cur_req.key;
                i_value      <= cur_req.value;
                i_after_slot <= cur_req.after_slot;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall, with an occasional long hold-off
    always @(posedge i_clk) begin
        t_table_result got;
        t_table_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_status, o_value_out, o_key_out, o_slot_out, o_live_count};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result differs: expected %p got %p", want, got);
                    end
                end
            end
            if (hold_request > 0) begin
                hold_cycles = hold_request;
                hold_request = 0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HOLD_LIMIT) begin
            $display("open_addressing_hash_table_unit: mismatch");
            $finish;
        end
    end

    // after_slot is given as an int and kept as its low 11 bits
    task automatic queue_req(logic [2:0] m, logic [31:0] k, logic [31:0] v, int a);
        t_table_req r;
        r.mode = m;
        r.key = k;
        r.value = v;
        r.after_slot = 11'(a);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(int unsigned v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[CNT_W-1:0];
        cap_reg = v & 11'h7FF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one random request, mostly from a small key pool so hits are common
    task automatic queue_random(int unsigned c);
        int unsigned       pick;
        logic [31:0]       k;
        int                a;
        int unsigned       lim;
        pick = $urandom_range(0, 99);
        k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
        lim = (c < 1) ? 1 : ((c > SLOTS) ? SLOTS : c);
        if ($urandom_range(0, 9) == 0)
            a = $urandom_range(0, 2047);
        else if (lim > 64)
            a = lim - $urandom_range(1, 64);
        else
            a = $urandom_range(0, lim) - 1;
        if (pick < 38)      queue_req(MODE_SET, k, $urandom, a);
        else if (pick < 63) queue_req(MODE_GET, k, $urandom, a);
        else if (pick < 80) queue_req(MODE_ERASE, k, $urandom, a);
        else if (pick < 95) queue_req(MODE_ITER, k, $urandom, a);
        else if (pick < 97) queue_req(MODE_CLEAR, k, $urandom, a);
        else                queue_req(3'($urandom_range(5, 7)), k, $urandom, a);
    endtask

    initial begin
        int unsigned caps [6];
        caps = '{37, 1024, 3, 2047, 0, 200};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = '0;
        i_key = '0;
        i_value = '0;
        i_after_slot = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        quiet_cycles = 0;
        hold_request = 0;
        send_idle_pct = 13;
        recv_stall_pct = 59;
        entries = 0;
        cap_reg = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            live_flag[i] = 1'b0;
            tomb_flag[i] = 1'b0;
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++)
            key_pool[i] = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every mode, tombstone reuse, iterate bounds
        queue_req(MODE_ITER, 0, 0, -1);
        queue_req(MODE_SET, 32'h0, 32'hFFFF_FFFF, 0);
        queue_req(MODE_SET, 32'hFFFF_FFFF, 32'h0, 0);
        queue_req(MODE_SET, 32'h0, 32'h1234_5678, 0);
        queue_req(MODE_GET, 32'h0, 0, 0);
        queue_req(MODE_GET, 32'hFFFF_FFFF, 0, 0);
        queue_req(MODE_GET, 32'h5A5A_A5A5, 0, 0);
        queue_req(MODE_ERASE, 32'h0, 0, 0);
        queue_req(MODE_ERASE, 32'h0, 0, 0);
        queue_req(MODE_GET, 32'h0, 0, 0);
        queue_req(MODE_SET, 32'h0, 32'h8000_0001, 0);
        queue_req(MODE_ITER, 0, 0, -1);
        queue_req(MODE_ITER, 0, 0, -1024);
        queue_req(MODE_ITER, 0, 0, 1023);
        queue_req(MODE_ITER, 0, 0, 1022);
        queue_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1023);
        queue_req(3'd6, 0, 0, 0);
        queue_req(3'd7, 0, 0, 0);
        queue_req(MODE_CLEAR, 0, 0, 0);
        queue_req(MODE_ITER, 0, 0, -1);
        wait_idle();

        // a single slot: fill, then full, then tombstone reuse
        write_capacity(1);
        queue_req(MODE_SET, 32'h0102_0304, 32'hAAAA_5555, 0);
        queue_req(MODE_SET, 32'h0506_0708, 32'h5555_AAAA, 0);
        queue_req(MODE_ERASE, 32'h0102_0304, 0, 0);
        queue_req(MODE_SET, 32'h0506_0708, 32'h1, 0);
        queue_req(MODE_ITER, 0, 0, -1);
        wait_idle();

        // random phases under changing capacity and idling
        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            if (p < 2) begin
                send_idle_pct = 13;
                recv_stall_pct = 59;
            end else if (p < 4) begin
                send_idle_pct = 59;
                recv_stall_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (p == 4)
                hold_request = 400;
            for (int n = 0; n < 265; n++)
                queue_random(caps[p]);
            wait_idle();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("open_addressing_hash_table_unit: match");
        else
            $display("open_addressing_hash_table_unit: mismatch");
        $finish;
    end

endmodule
